@@ hdl/pcng_pkg.sv @@
package pcng_pkg;

  localparam int MAX_CELLS_PER_AXIS = 64;
  localparam int MIN_CELLS          = 3;
  localparam int NUM_SLOTS          = 26;

  // Field and register widths.
  localparam int REG_W    = 7;
  localparam int CELL_W   = 18;
  localparam int SLOT_W   = 5;
  localparam int AXIS_W   = $clog2(MAX_CELLS_PER_AXIS);
  localparam int CNT_W    = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int PLANE_W  = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);
  localparam int TOTAL_W  =
    $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);

  // The divider retires two quotient bits per cycle.
  localparam int DIV_STEPS = CELL_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_X_CELLS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_CELLS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_Z_CELLS = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Per-axis step codes; they also index the three precomputed offsets.
  typedef logic [1:0] delta_t;
  localparam delta_t D_ZERO  = 2'd0;
  localparam delta_t D_PLUS  = 2'd1;
  localparam delta_t D_MINUS = 2'd2;

  typedef struct packed {
    delta_t dx;
    delta_t dy;
    delta_t dz;
  } step_t;

  // Effective axis counts after clamping.
  typedef struct packed {
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
    logic [CNT_W-1:0] nz;
  } geom_t;

  // One decoded cell: for each axis the offsets of the same, next and
  // previous coordinate (element 0, 1 and 2), already scaled by the stride.
  typedef struct packed {
    logic                           bad;
    logic [2:0][CELL_W-1:0]         zoff;
    logic [2:0][PLANE_W-1:0]        yoff;
    logic [2:0][AXIS_W-1:0]         xpos;
  } entry_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [REG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v < REG_W'(MIN_CELLS)) begin
      r = CNT_W'(MIN_CELLS);
    end else if (v > REG_W'(MAX_CELLS_PER_AXIS)) begin
      r = CNT_W'(MAX_CELLS_PER_AXIS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  // Coordinate plus a step of -1, 0 or +1, modulo n.
  function automatic logic [AXIS_W-1:0] wrap_step(input logic [AXIS_W-1:0] coord,
                                                   input delta_t d,
                                                   input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0]  up;
    logic [CNT_W-1:0]  top;
    logic [AXIS_W-1:0] r;
    up  = CNT_W'(coord) + 1'b1;
    top = n - 1'b1;
    if (d == D_PLUS) begin
      r = (up == n) ? '0 : up[AXIS_W-1:0];
    end else if (d == D_MINUS) begin
      r = (coord == '0) ? top[AXIS_W-1:0] : coord - 1'b1;
    end else begin
      r = coord;
    end
    return r;
  endfunction

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                              input logic b,
                                              input logic [CNT_W-1:0] d);
    logic [CNT_W:0]   t;
    logic [CNT_W:0]   diff;
    logic [CNT_W:0]   r;
    t    = {rem, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r = {1'b1, diff[CNT_W-1:0]};
    end else begin
      r = {1'b0, t[CNT_W-1:0]};
    end
    return r;
  endfunction

  // Fixed neighbor order: eight in-plane moves, repeated in the layer above
  // and the layer below, then straight up and straight down.
  function automatic step_t slot_step(input logic [SLOT_W-1:0] k);
    step_t s;
    unique case (k[2:0])
      3'd0: begin s.dx = D_MINUS; s.dy = D_PLUS;  end
      3'd1: begin s.dx = D_MINUS; s.dy = D_ZERO;  end
      3'd2: begin s.dx = D_MINUS; s.dy = D_MINUS; end
      3'd3: begin s.dx = D_ZERO;  s.dy = D_PLUS;  end
      3'd4: begin s.dx = D_ZERO;  s.dy = D_MINUS; end
      3'd5: begin s.dx = D_PLUS;  s.dy = D_PLUS;  end
      3'd6: begin s.dx = D_PLUS;  s.dy = D_ZERO;  end
      3'd7: begin s.dx = D_PLUS;  s.dy = D_MINUS; end
    endcase
    if (k < SLOT_W'(8)) begin
      s.dz = D_ZERO;
    end else if (k < SLOT_W'(16)) begin
      s.dz = D_PLUS;
    end else if (k < SLOT_W'(24)) begin
      s.dz = D_MINUS;
    end else begin
      s.dx = D_ZERO;
      s.dy = D_ZERO;
      s.dz = (k == SLOT_W'(24)) ? D_PLUS : D_MINUS;
    end
    return s;
  endfunction

endpackage

@@ hdl/periodic_cell_neighbor_generator_core.sv @@
// Periodic neighbor-cell generator for a 3-D cell list. Each cell index taken on
// the in_ channel (numbered x fastest, then row y, then layer z) produces 26
// transactions on the out_ channel: the eight in-plane neighbors, the same eight
// in the layer above, the same eight in the layer below, then the cell straight
// above and straight below, every coordinate wrapping around its axis. The axis
// counts are written through the cfg_ port (index 0 x, 1 y, 2 z); values below 3
// act as 3 and values above 64 act as 64. An index at or beyond x*y*z is still
// answered with 26 transactions, flagged in out_tuser with a zero neighbor.
// The output channel moves one neighbor per cycle while out_tready stays high and
// sets the sustained rate. The front end takes the index, divides it by the x
// count and then by the y count at two quotient bits a cycle, builds the wrapped
// offsets and hands the entry off. It runs ahead of the output through a
// two-entry queue, so a new cell is taken while earlier ones are still being
// emitted. Allow two cycles after a configuration write before the next cell is
// presented; the derived plane and total counts are registered from the
// configuration.
module periodic_cell_neighbor_generator_core (
  input  logic                               clk,
  input  logic                               rst_n,

  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [pcng_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pcng_pkg::REG_W-1:0]         cfg_wdata,

  // Cell index stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // [17:0] cell_index, rest zero

  // Neighbor stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // [4:0] direction,
                                                         // [22:5] neighbor_index, rest zero
  output logic                               out_tuser,  // [0] bad_cell
  output logic                               out_tlast
);

  logic [pcng_pkg::REG_W-1:0]   x_cells_r, x_cells_nxt;
  logic [pcng_pkg::REG_W-1:0]   y_cells_r, y_cells_nxt;
  logic [pcng_pkg::REG_W-1:0]   z_cells_r, z_cells_nxt;
  pcng_pkg::geom_t              geom;

  logic                         fq_valid, fq_ready;
  pcng_pkg::entry_t             fq_entry;
  logic                         qb_valid, qb_ready;
  pcng_pkg::entry_t             qb_entry;

  logic [pcng_pkg::SLOT_W-1:0]  dir;
  logic [pcng_pkg::CELL_W-1:0]  nbr;

  // Register writes; an index past the register list is ignored.
  always_comb begin
    x_cells_nxt = x_cells_r;
    y_cells_nxt = y_cells_r;
    z_cells_nxt = z_cells_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        pcng_pkg::REG_X_CELLS: x_cells_nxt = cfg_wdata;
        pcng_pkg::REG_Y_CELLS: y_cells_nxt = cfg_wdata;
        pcng_pkg::REG_Z_CELLS: z_cells_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_cells_r <= pcng_pkg::REG_W'(pcng_pkg::MIN_CELLS);
      y_cells_r <= pcng_pkg::REG_W'(pcng_pkg::MIN_CELLS);
      z_cells_r <= pcng_pkg::REG_W'(pcng_pkg::MIN_CELLS);
    end else begin
      x_cells_r <= x_cells_nxt;
      y_cells_r <= y_cells_nxt;
      z_cells_r <= z_cells_nxt;
    end
  end

  // Clamped counts seen by the datapath.
  assign geom.nx = pcng_pkg::eff_count(x_cells_r);
  assign geom.ny = pcng_pkg::eff_count(y_cells_r);
  assign geom.nz = pcng_pkg::eff_count(z_cells_r);

  // Front end: splits the index into coordinates and builds wrapped offsets.
  pcng_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cell  (in_tdata[pcng_pkg::CELL_W-1:0]),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_entry  (fq_entry)
  );

  // Decoupling queue between the front end and the emitter.
  pcng_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_entry  (fq_entry),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_entry (qb_entry)
  );

  // Back end: walks the 26 slots into an output register, one per cycle unless stalled.
  pcng_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_entry      (qb_entry),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_dir      (dir),
    .out_neighbor (nbr),
    .out_bad      (out_tuser),
    .out_last     (out_tlast)
  );

  assign out_tdata = {1'b0, nbr, dir};

endmodule

@@ hdl/pcng_front.sv @@
module pcng_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcng_pkg::geom_t               geom,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcng_pkg::CELL_W-1:0]   in_cell,
  output logic                          q_valid,
  input  logic                          q_ready,
  output pcng_pkg::entry_t              q_entry
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MAP  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  localparam int CW = pcng_pkg::CNT_W;
  localparam int AW = pcng_pkg::AXIS_W;
  localparam int PW = pcng_pkg::PLANE_W;
  localparam int LW = pcng_pkg::CELL_W;

  logic [2:0]                        state_r, state_nxt;
  logic [LW-1:0]                     c_r, c_nxt;
  logic [LW-1:0]                     dvd_r, dvd_nxt;
  logic [CW-1:0]                     rem_r, rem_nxt;
  logic [pcng_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]                     x_r, x_nxt;
  logic [AW-1:0]                     y_r, y_nxt;
  logic [AW-1:0]                     z_r, z_nxt;
  pcng_pkg::entry_t                  entry_r, entry_nxt;
  logic [PW-1:0]                     plane_r;
  logic [pcng_pkg::TOTAL_W-1:0]      total_r;

  logic [2*CW-1:0]                   plane_full;
  logic [PW+CW-1:0]                  total_full;
  logic [CW-1:0]                     divisor;
  logic [CW:0]                       s1, s2;
  logic [LW-1:0]                     dvd_shift;
  logic                              div_done;
  logic [AW-1:0]                     wx, wy, wz;
  logic [AW+PW-1:0]                  zprod;
  logic [AW+CW-1:0]                  yprod;

  // Plane and total cell counts are registered, the total from the registered
  // plane; they are first used when the offsets are built, after both divisions.
  assign plane_full = {{CW{1'b0}}, geom.nx} * {{CW{1'b0}}, geom.ny};
  assign total_full = {{CW{1'b0}}, plane_r} * {{PW{1'b0}}, geom.nz};

  always_ff @(posedge clk) begin
    plane_r <= plane_full[PW-1:0];
    total_r <= total_full[pcng_pkg::TOTAL_W-1:0];
  end

  assign divisor   = (state_r == S_DIV2) ? geom.ny : geom.nx;
  assign s1        = pcng_pkg::div_step(rem_r, dvd_r[LW-1], divisor);
  assign s2        = pcng_pkg::div_step(s1[CW-1:0], dvd_r[LW-2], divisor);
  assign dvd_shift = {dvd_r[LW-3:0], s1[CW], s2[CW]};
  assign div_done  = (cnt_r == pcng_pkg::DIV_CNT_W'(pcng_pkg::DIV_STEPS - 1));

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = (state_r == S_PUSH);
  assign q_entry  = entry_r;

  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    entry_nxt = entry_r;
    wx        = '0;
    wy        = '0;
    wz        = '0;
    zprod     = '0;
    yprod     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          c_nxt     = in_cell;
          dvd_nxt   = in_cell;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        dvd_nxt = dvd_shift;
        rem_nxt = s2[CW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (div_done) begin
          // x is the remainder of c / nx; the quotient goes on to be split by ny.
          x_nxt     = s2[AW-1:0];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        dvd_nxt = dvd_shift;
        rem_nxt = s2[CW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (div_done) begin
          y_nxt     = s2[AW-1:0];
          z_nxt     = dvd_shift[AW-1:0];
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        entry_nxt.bad = (pcng_pkg::TOTAL_W'(c_r) >= total_r);
        for (int i = 0; i < 3; i++) begin
          wx    = pcng_pkg::wrap_step(x_r, pcng_pkg::delta_t'(i), geom.nx);
          wy    = pcng_pkg::wrap_step(y_r, pcng_pkg::delta_t'(i), geom.ny);
          wz    = pcng_pkg::wrap_step(z_r, pcng_pkg::delta_t'(i), geom.nz);
          zprod = {{PW{1'b0}}, wz} * {{AW{1'b0}}, plane_r};
          yprod = {{CW{1'b0}}, wy} * {{AW{1'b0}}, geom.nx};
          entry_nxt.zoff[i] = zprod[LW-1:0];
          entry_nxt.yoff[i] = yprod[PW-1:0];
          entry_nxt.xpos[i] = wx;
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (q_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    entry_r <= entry_nxt;
  end

endmodule

@@ hdl/pcng_fifo.sv @@
module pcng_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcng_pkg::entry_t in_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output pcng_pkg::entry_t out_entry
);

  localparam int PTR_W = pcng_pkg::QPTR_W;

  pcng_pkg::entry_t   slot_r [pcng_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               push, pop;

  assign in_ready  = (count_r != (PTR_W+1)'(pcng_pkg::QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_entry = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_entry;
    end
  end

endmodule

@@ hdl/pcng_back.sv @@
module pcng_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  pcng_pkg::entry_t              q_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcng_pkg::SLOT_W-1:0]   out_dir,
  output logic [pcng_pkg::CELL_W-1:0]   out_neighbor,
  output logic                          out_bad,
  output logic                          out_last
);

  localparam int LW = pcng_pkg::CELL_W;
  localparam int SW = pcng_pkg::SLOT_W;

  pcng_pkg::entry_t   cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SW-1:0]      dir_r;
  logic [LW-1:0]      nbr_r;
  logic               bad_r;
  logic               last_r;

  pcng_pkg::step_t    st;
  logic [1:0]         zi, yi, xi;
  logic [LW:0]        sum;
  logic [LW-1:0]      nbr;
  logic               adv, finishing, take;

  function automatic logic [1:0] code_index(input pcng_pkg::delta_t d);
    logic [1:0] r;
    if (d == pcng_pkg::D_PLUS) begin
      r = 2'd1;
    end else if (d == pcng_pkg::D_MINUS) begin
      r = 2'd2;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  assign st  = pcng_pkg::slot_step(slot_r);
  assign zi  = code_index(st.dz);
  assign yi  = code_index(st.dy);
  assign xi  = code_index(st.dx);
  assign sum = {1'b0, cur_r.zoff[zi]}
             + (LW+1)'(cur_r.yoff[yi])
             + (LW+1)'(cur_r.xpos[xi]);
  assign nbr = cur_r.bad ? '0 : sum[LW-1:0];

  assign adv       = cur_valid_r && (!out_valid_r || out_ready);
  assign finishing = adv && (slot_r == pcng_pkg::LAST_SLOT);
  assign q_ready   = !cur_valid_r || finishing;
  assign take      = q_valid && q_ready;

  always_comb begin
    cur_nxt       = take ? q_entry : cur_r;
    cur_valid_nxt = take ? 1'b1 : (finishing ? 1'b0 : cur_valid_r);
    if (take || finishing) begin
      slot_nxt = '0;
    end else if (adv) begin
      slot_nxt = slot_r + 1'b1;
    end else begin
      slot_nxt = slot_r;
    end
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv) begin
      dir_r  <= slot_r;
      nbr_r  <= nbr;
      bad_r  <= cur_r.bad;
      last_r <= (slot_r == pcng_pkg::LAST_SLOT);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dir      = dir_r;
  assign out_neighbor = nbr_r;
  assign out_bad      = bad_r;
  assign out_last     = last_r;

  // The end-of-cell marker sits on the final slot only.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (dir_r == pcng_pkg::LAST_SLOT)))
    else $error("end marker does not match the final slot");

  // An out-of-range cell never names a neighbor.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (nbr_r == '0))
    else $error("out-of-range cell produced a nonzero neighbor");

  // Within a cell the slots come out in order without gaps.
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !last_r) |=>
      (out_valid_r && (dir_r == $past(dir_r) + 1'b1)))
    else $error("slot sequence broken");

  // A new cell is taken from the queue only when the slot counter restarts.
  a_take_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (cur_valid_r && (slot_r == '0)))
    else $error("cell loaded without restarting the slot counter");

endmodule

@@ tb/periodic_cell_neighbor_generator_core_tb.sv @@
module periodic_cell_neighbor_generator_core_tb;

  // The run ends when this many cycles pass in a row with no transaction on any port.
  localparam int STALL_LIMIT = 4000;
  // The long receiver hold-off is counted in cycles by the receiver process itself.
  localparam int HOLD_CYCLES = 300;
  // Quiet cycles after the last result, enough to catch any stray extra output.
  localparam int TAIL_CYCLES = 60;

  // Expected neighbor stream for all accepted cells. The class keeps its own
  // copy of the axis registers, so it must only be updated while the block is idle.
  class neighbor_board;
    typedef struct packed {
      logic [pcng_pkg::SLOT_W-1:0] dir;
      logic [pcng_pkg::CELL_W-1:0] nbr;
      logic                        bad;
      logic                        last;
    } neighbor_t;

    neighbor_t expected_nbrs[$];
    int        errors;
    logic [pcng_pkg::REG_W-1:0] x_cells, y_cells, z_cells;

    function new();
      errors  = 0;
      x_cells = pcng_pkg::REG_W'(3);
      y_cells = pcng_pkg::REG_W'(3);
      z_cells = pcng_pkg::REG_W'(3);
    endfunction

    function void set_reg(logic [pcng_pkg::CFG_ADDR_W-1:0] idx,
                          logic [pcng_pkg::REG_W-1:0] val);
      case (idx)
        pcng_pkg::REG_X_CELLS: x_cells = val;
        pcng_pkg::REG_Y_CELLS: y_cells = val;
        pcng_pkg::REG_Z_CELLS: z_cells = val;
        default: ;
      endcase
    endfunction

    // Register values outside the legal span act as the nearest bound.
    function int axis_count(logic [pcng_pkg::REG_W-1:0] v);
      if (v < pcng_pkg::MIN_CELLS) return pcng_pkg::MIN_CELLS;
      if (v > pcng_pkg::MAX_CELLS_PER_AXIS) return pcng_pkg::MAX_CELLS_PER_AXIS;
      return int'(v);
    endfunction

    function int cell_total();
      return axis_count(x_cells) * axis_count(y_cells) * axis_count(z_cells);
    endfunction

    function int wrap_coord(int c, int d, int n);
      if (d > 0) return (c + 1 == n) ? 0 : c + 1;
      if (d < 0) return (c == 0) ? n - 1 : c - 1;
      return c;
    endfunction

    function int pending();
      return expected_nbrs.size();
    endfunction

    // Queue the 26 neighbor results that one accepted cell index produces.
    function void note_cell(logic [pcng_pkg::CELL_W-1:0] cell_idx);
      int nx, ny, nz, plane, x, y, z, dx, dy, dz, nb;
      int step_x[8];
      int step_y[8];
      logic bad;
      neighbor_t e;
      step_x = '{-1, -1, -1, 0, 0, 1, 1, 1};
      step_y = '{1, 0, -1, 1, -1, 1, 0, -1};
      nx    = axis_count(x_cells);
      ny    = axis_count(y_cells);
      nz    = axis_count(z_cells);
      plane = nx * ny;
      bad   = (int'(cell_idx) >= plane * nz);
      x = 0;
      y = 0;
      z = 0;
      if (!bad) begin
        x = int'(cell_idx) % nx;
        y = (int'(cell_idx) / nx) % ny;
        z = int'(cell_idx) / plane;
      end
      for (int k = 0; k < pcng_pkg::NUM_SLOTS; k++) begin
        if (k < 24) begin
          dx = step_x[k % 8];
          dy = step_y[k % 8];
          dz = (k < 8) ? 0 : ((k < 16) ? 1 : -1);
        end else begin
          dx = 0;
          dy = 0;
          dz = (k == 24) ? 1 : -1;
        end
        nb = 0;
        if (!bad) begin
          nb = wrap_coord(z, dz, nz) * plane + wrap_coord(y, dy, ny) * nx
             + wrap_coord(x, dx, nx);
        end
        e.dir  = pcng_pkg::SLOT_W'(k);
        e.nbr  = pcng_pkg::CELL_W'(nb);
        e.bad  = bad;
        e.last = (k == pcng_pkg::NUM_SLOTS - 1);
        expected_nbrs.push_back(e);
      end
    endfunction

    // Compare one output transaction against the oldest expectation. The
    // unused top bit of tdata must be zero as well.
    function void check_neighbor(logic [23:0] tdata, logic tuser, logic tlast);
      neighbor_t got, want;
      got.dir  = tdata[pcng_pkg::SLOT_W-1:0];
      got.nbr  = tdata[pcng_pkg::SLOT_W+pcng_pkg::CELL_W-1:pcng_pkg::SLOT_W];
      got.bad  = tuser;
      got.last = tlast;
      if (expected_nbrs.size() == 0) begin
        $display("%0t: unexpected neighbor dir=%0d nbr=%0d bad=%0b last=%0b",
                 $time, got.dir, got.nbr, got.bad, got.last);
        errors++;
        return;
      end
      want = expected_nbrs.pop_front();
      if (got !== want || tdata[23] !== 1'b0) begin
        $display("%0t: neighbor mismatch expected dir=%0d nbr=%0d bad=%0b last=%0b",
                 $time, want.dir, want.nbr, want.bad, want.last);
        $display("%0t:                   actual dir=%0d nbr=%0d bad=%0b last=%0b pad=%0b",
                 $time, got.dir, got.nbr, got.bad, got.last, tdata[23]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [pcng_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [pcng_pkg::REG_W-1:0]      cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [23:0]                     in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [23:0]                     out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  neighbor_board board;

  // Idling percentages for the two sides; the main sequence changes them per phase.
  int send_idle_pct;
  int recv_idle_pct;
  // Set by the main sequence to make the receiver hold off for a long stretch.
  bit hold_req;
  int quiet_cycles;

  periodic_cell_neighbor_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drops tready at random, or for a long stretch when asked. All
  // changes happen at the falling edge so the rising edge sees stable values.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every output transaction is checked at the edge where it is accepted.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      board.check_neighbor(out_tdata, out_tuser, out_tlast);
    end
  end

  // Watchdog: a run of cycles with no transaction anywhere means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("periodic_cell_neighbor_generator_core_tb failed");
      $finish;
    end
  end

  // Offer one cell index and wait for its transaction. Called at a falling edge
  // and returns at a falling edge with tvalid still high; the next call or a
  // drain decides whether it stays high, so it is assigned once per step.
  task automatic send_cell(input logic [pcng_pkg::CELL_W-1:0] cell_idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, cell_idx};
    do @(posedge clk); while (!in_tready);
    board.note_cell(cell_idx);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected neighbor has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pcng_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [pcng_pkg::REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    board.set_reg(idx, val);
  endtask

  // New axis counts are only written once the block has gone idle. The
  // derived counts inside the block lag the write.
  task automatic program_geometry(input logic [pcng_pkg::REG_W-1:0] xv,
                                  input logic [pcng_pkg::REG_W-1:0] yv,
                                  input logic [pcng_pkg::REG_W-1:0] zv);
    drain_results();
    repeat (4) @(negedge clk);
    write_reg(pcng_pkg::REG_X_CELLS, xv);
    write_reg(pcng_pkg::REG_Y_CELLS, yv);
    write_reg(pcng_pkg::REG_Z_CELLS, zv);
    cfg_we <= 1'b0;
    repeat (3) @(negedge clk);
  endtask

  // Mostly in-range cells of the current box, some past its end, a few raw
  // 18-bit values.
  task automatic random_cells(input int count);
    int total;
    int pick;
    logic [pcng_pkg::CELL_W-1:0] cell_idx;
    total = board.cell_total();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85 || total >= (1 << pcng_pkg::CELL_W)) begin
        cell_idx = pcng_pkg::CELL_W'($urandom_range(0, total - 1));
      end else if (pick < 95) begin
        cell_idx = pcng_pkg::CELL_W'($urandom_range(total, (1 << pcng_pkg::CELL_W) - 1));
      end else begin
        cell_idx = pcng_pkg::CELL_W'($urandom);
      end
      send_cell(cell_idx);
    end
  endtask

  initial begin
    board         = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 13;
    recv_idle_pct = 48;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset geometry 3x3x3: the first cell, corners and the center, where
    // every axis wraps, then indexes past the box: the first, 131072 and the top index.
    send_cell(18'd0);
    send_cell(18'd2);
    send_cell(18'd6);
    send_cell(18'd8);
    send_cell(18'd13);
    send_cell(18'd18);
    send_cell(18'd20);
    send_cell(18'd24);
    send_cell(18'd26);
    send_cell(18'd27);
    send_cell(18'd131072);
    send_cell(18'h3FFFF);

    // Largest box: 64 per axis fills the whole 18-bit index space.
    program_geometry(7'd64, 7'd64, 7'd64);
    send_cell(18'd0);
    send_cell(18'd63);
    send_cell(18'd4095);
    send_cell(18'd4096);
    send_cell(18'd258048);
    send_cell(18'h3FFFF);
    random_cells(20);

    // Out-of-span register values: 127 acts as 64, 0 and 2 act as 3.
    program_geometry(7'd127, 7'd0, 7'd2);
    send_cell(18'd575);
    send_cell(18'd576);
    random_cells(20);

    send_idle_pct = 48;
    recv_idle_pct = 13;
    program_geometry(7'd0, 7'd127, 7'd1);
    random_cells(20);

    program_geometry(7'd3, 7'd3, 7'd64);
    random_cells(20);

    program_geometry(pcng_pkg::REG_W'($urandom_range(0, 127)),
                     pcng_pkg::REG_W'($urandom_range(0, 127)),
                     pcng_pkg::REG_W'($urandom_range(0, 127)));
    random_cells(20);

    // No idling from here on. The receiver first holds off for a long
    // stretch while cells keep coming, so the queue fills and in_tready drops.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_geometry(pcng_pkg::REG_W'($urandom_range(3, 20)),
                     pcng_pkg::REG_W'($urandom_range(3, 20)),
                     pcng_pkg::REG_W'($urandom_range(3, 20)));
    hold_req = 1'b1;
    random_cells(20);

    program_geometry(pcng_pkg::REG_W'($urandom_range(0, 127)),
                     pcng_pkg::REG_W'($urandom_range(0, 127)),
                     pcng_pkg::REG_W'($urandom_range(0, 127)));
    random_cells(20);

    program_geometry(pcng_pkg::REG_W'($urandom_range(3, 20)),
                     pcng_pkg::REG_W'($urandom_range(3, 20)),
                     pcng_pkg::REG_W'($urandom_range(3, 20)));
    random_cells(20);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("periodic_cell_neighbor_generator_core_tb passed");
    end else begin
      $display("periodic_cell_neighbor_generator_core_tb failed");
    end
    $finish;
  end

endmodule
